/* rtl/core/glos_pkg.sv */
// Shared constants, register indexes and mask helpers for the line-of-sight block.
// No dependencies.
`default_nettype none

package glos_pkg;

    localparam int WINDOW_RADIUS = 16;
    localparam int MAP_SIZE      = 1024;
    localparam int WIN           = 2 * WINDOW_RADIUS + 1;
    localparam int ROW_W         = $clog2(WIN);
    localparam int DIST_W        = 5;
    localparam int COORD_W       = 10;
    localparam int POS_W         = COORD_W + 2;   // signed absolute position around window
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 10;
    localparam int S_TDATA_W     = 96;
    localparam int M_TDATA_W     = 8;
    localparam int WROW_W        = 2 * WIN;       // block bits low, door bits high

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOOR_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOOR_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOOR_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd5;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // columns within k of the window center
    function automatic logic [WIN-1:0] col_box(input logic [DIST_W-1:0] k);
        logic [WIN-1:0] m;
        m = '0;
        for (int j = 0; j < WIN; j++) begin
            if ((j >= WINDOW_RADIUS - int'(k)) && (j <= WINDOW_RADIUS + int'(k)))
                m[j] = 1'b1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/grid_line_of_sight_wavefront.sv */
// Line-of-sight wavefront: window row store, reach map store and the build sequencer.
// Depends on glos_pkg and glos_ram.
//
// Usage: the s_ channel carries loads (s_tuser low) and queries (s_tuser high).
// A load writes one window row of block and door bits. The load of the last
// row starts a build that rewrites the reach map row by row: it seeds the map,
// then runs one sweep per ring d = 2 .. md-1, reading one row a cycle from the
// window and reach memories and writing one row back; md is max_distance
// clamped to 16. No beat is taken during a build. A query passes through
// address, memory read and result steps and returns one beat on the m_ channel.
// A finished result waits in the output register while loads keep flowing; a
// second query waits until the receiver has taken the first. Configuration
// writes are meant for idle periods. After reset the registers hold their
// defaults and queries return 0 until the first build; the window rows are
// undefined until loaded.
`default_nettype none

module grid_line_of_sight_wavefront (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_wr_en,
    input  wire  [glos_pkg::CFG_IDX_W-1:0]        cfg_wr_index,
    input  wire  [glos_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // row_index[5:0], block_row[38:6], door_row[71:39], target_x[81:72],
    // target_y[91:82], zero fill above
    input  wire  [glos_pkg::S_TDATA_W-1:0]        s_tdata,
    // command[0]
    input  wire                                   s_tuser,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // visibility[4:0], zero fill above
    output logic [glos_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int R   = glos_pkg::WINDOW_RADIUS;
    localparam int W   = glos_pkg::WIN;
    localparam int RW  = glos_pkg::ROW_W;
    localparam int DW  = glos_pkg::DIST_W;
    localparam int CW  = glos_pkg::COORD_W;
    localparam int PW  = glos_pkg::POS_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_QADDR, ST_QRES, ST_INIT, ST_SWEEP, ST_FLUSH
    } state_t;

    // payload fields
    logic [RW-1:0] in_row;
    logic [W-1:0]  in_block, in_door;
    logic [CW-1:0] in_tx, in_ty;
    assign in_row   = s_tdata[5:0];
    assign in_block = s_tdata[38:6];
    assign in_door  = s_tdata[71:39];
    assign in_tx    = s_tdata[81:72];
    assign in_ty    = s_tdata[91:82];

    state_t        state_reg, state_next;
    logic [DW-1:0] max_dist_reg;
    logic          door_en_reg;
    logic [CW-1:0] door_x_reg, door_y_reg, center_x_reg, center_y_reg;
    logic [RW-1:0] a_reg, a_next;
    logic [DW-1:0] d_reg, d_next;
    logic [DW-1:0] mdb_reg, mdb_next;
    logic          rv_reg, rv_next;
    logic [RW-1:0] rrow_reg, rrow_next;
    logic [W-1:0]  p_prev_reg, p_prev_next, p_cur_reg, p_cur_next;
    logic [W-1:0]  r_cur_reg, r_cur_next;
    logic [RW-1:0] q_row_reg, q_row_next, q_col_reg, q_col_next;
    logic [DW-1:0] q_ring_reg, q_ring_next;
    logic          q_ok_reg, q_ok_next;
    logic          built_reg, built_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [DW-1:0] vis_reg, vis_next;

    logic          win_we;
    logic [W*2-1:0] win_rdata;
    logic          reach_we;
    logic [RW-1:0] reach_waddr, reach_raddr;
    logic [W-1:0]  reach_wdata, reach_rdata;

    logic [DW-1:0] mdc;
    assign mdc = (max_dist_reg > DW'(R)) ? DW'(R) : max_dist_reg;

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign win_we   = accept && (s_tuser == glos_pkg::CMD_LOAD) && (in_row < RW'(W));

    glos_ram #(.WIDTH(glos_pkg::WROW_W), .DEPTH(W)) u_win_ram (
        .aclk    (aclk),
        .wr_en   (win_we),
        .wr_addr (in_row),
        .wr_data ({in_door, in_block}),
        .rd_addr (a_reg),
        .rd_data (win_rdata)
    );

    glos_ram #(.WIDTH(W), .DEPTH(W)) u_reach_ram (
        .aclk    (aclk),
        .wr_en   (reach_we),
        .wr_addr (reach_waddr),
        .wr_data (reach_wdata),
        .rd_addr (reach_raddr),
        .rd_data (reach_rdata)
    );

    // sweep datapath: passable and reached bits of the row arriving from memory
    logic [W-1:0]  pass_row, p_inc, spread, ring_mask, new_bits;
    logic          row_in_box, row_is_edge;
    logic          sweep_wr;
    logic [RW-1:0] wr_row;

    always_comb begin
        logic signed [PW-1:0] base_x, ay, ax;
        logic                 in_y, door_y_eq;
        logic [W-1:0]         or3;
        base_x = $signed({2'b00, center_x_reg}) - PW'(R);
        ay     = $signed({2'b00, center_y_reg}) - PW'(R) + $signed(PW'(rrow_reg));
        in_y      = (ay >= PW'(1)) && (ay < PW'(glos_pkg::MAP_SIZE));
        door_y_eq = (ay == $signed({2'b00, door_y_reg}));
        for (int j = 0; j < W; j++) begin
            ax = base_x + PW'(j);
            pass_row[j] = in_y && (ax >= PW'(1)) && (ax < PW'(glos_pkg::MAP_SIZE)) &&
                ((door_en_reg && win_rdata[W + j] &&
                  !(door_y_eq && (ax == $signed({2'b00, door_x_reg})))) ||
                 !win_rdata[j]);
        end
        row_in_box = ((7'(rrow_reg) + 7'(d_reg)) > 7'(R)) &&
                     (7'(rrow_reg) < (7'(R) + 7'(d_reg)));
        p_inc  = row_in_box ? (pass_row & reach_rdata & glos_pkg::col_box(d_reg - 5'd1))
                            : '0;
        or3    = p_prev_reg | p_cur_reg | p_inc;
        spread = or3 | (or3 << 1) | (or3 >> 1);
        wr_row = rrow_reg - RW'(1);
        row_is_edge = (7'(wr_row) + 7'(d_reg) == 7'(R)) || (7'(wr_row) == 7'(R) + 7'(d_reg));
        ring_mask = row_is_edge ? glos_pkg::col_box(d_reg)
                                : (glos_pkg::col_box(d_reg) & ~glos_pkg::col_box(d_reg - 5'd1));
        new_bits = ring_mask & spread;
        sweep_wr = rv_reg && ((7'(rrow_reg) + 7'(d_reg)) > 7'(R));
    end

    // query address and range
    logic signed [CW:0] ox, oy;
    logic [CW-1:0]      abs_x, abs_y;
    always_comb begin
        ox    = $signed({1'b0, in_tx}) - $signed({1'b0, center_x_reg});
        oy    = $signed({1'b0, in_ty}) - $signed({1'b0, center_y_reg});
        abs_x = ox[CW] ? CW'(-ox) : ox[CW-1:0];
        abs_y = oy[CW] ? CW'(-oy) : oy[CW-1:0];
    end

    logic [DW-1:0] q_val;
    always_comb begin
        if (q_ring_reg == '0)
            q_val = DW'(1);
        else if (reach_rdata[q_col_reg])
            q_val = q_ring_reg + DW'(1);
        else
            q_val = '0;
        if (!q_ok_reg || (q_val >= mdc))
            q_val = '0;
    end

    always_comb begin
        state_next    = state_reg;
        a_next        = a_reg;
        d_next        = d_reg;
        mdb_next      = mdb_reg;
        rv_next       = 1'b0;
        rrow_next     = rrow_reg;
        p_prev_next   = p_prev_reg;
        p_cur_next    = p_cur_reg;
        r_cur_next    = r_cur_reg;
        q_row_next    = q_row_reg;
        q_col_next    = q_col_reg;
        q_ring_next   = q_ring_reg;
        q_ok_next     = q_ok_reg;
        built_next    = built_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        vis_next      = vis_reg;
        reach_we      = 1'b0;
        reach_waddr   = wr_row;
        reach_wdata   = r_cur_reg | new_bits;
        reach_raddr   = q_row_reg;

        if (rv_reg) begin
            p_prev_next = p_cur_reg;
            p_cur_next  = p_inc;
            r_cur_next  = reach_rdata;
            if (sweep_wr)
                reach_we = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == glos_pkg::CMD_QUERY) begin
                        q_row_next  = RW'(R) + oy[RW-1:0];
                        q_col_next  = RW'(R) + ox[RW-1:0];
                        q_ring_next = (abs_x > abs_y) ? abs_x[DW-1:0] : abs_y[DW-1:0];
                        q_ok_next   = built_reg && (abs_x < CW'(mdc)) && (abs_y < CW'(mdc));
                        state_next  = ST_QADDR;
                    end else if (in_row == RW'(W - 1)) begin
                        mdb_next   = mdc;
                        built_next = 1'b1;
                        a_next     = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_QADDR: state_next = ST_QRES;
            ST_QRES: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    vis_next      = q_val;
                    state_next    = ST_IDLE;
                end
            end
            ST_INIT: begin
                // seed: center and its eight neighbors reached, all else clear
                reach_we    = 1'b1;
                reach_waddr = a_reg;
                reach_wdata = ((a_reg >= RW'(R - 1)) && (a_reg <= RW'(R + 1)))
                              ? glos_pkg::col_box(DW'(1)) : '0;
                a_next = a_reg + RW'(1);
                if (a_reg == RW'(W - 1)) begin
                    if (mdb_reg > DW'(2)) begin
                        d_next     = DW'(2);
                        a_next     = RW'(R - 3);
                        state_next = ST_SWEEP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SWEEP: begin
                reach_raddr = a_reg;
                rv_next     = 1'b1;
                rrow_next   = a_reg;
                if (7'(a_reg) == 7'(R) + 7'(d_reg) + 7'd1)
                    state_next = ST_FLUSH;
                else
                    a_next = a_reg + RW'(1);
            end
            ST_FLUSH: begin
                if (d_reg + DW'(1) < mdb_reg) begin
                    d_next     = d_reg + DW'(1);
                    a_next     = RW'(7'(R) - 7'(d_reg) - 7'd2);
                    state_next = ST_SWEEP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rv_reg       <= 1'b0;
            built_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            max_dist_reg <= DW'(16);
            door_en_reg  <= 1'b0;
            door_x_reg   <= '0;
            door_y_reg   <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
        end else begin
            state_reg    <= state_next;
            rv_reg       <= rv_next;
            built_reg    <= built_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    glos_pkg::REG_MAX_DISTANCE: max_dist_reg <= cfg_wr_data[DW-1:0];
                    glos_pkg::REG_DOOR_ENABLE:  door_en_reg  <= cfg_wr_data[0];
                    glos_pkg::REG_DOOR_X:       door_x_reg   <= cfg_wr_data;
                    glos_pkg::REG_DOOR_Y:       door_y_reg   <= cfg_wr_data;
                    glos_pkg::REG_CENTER_X:     center_x_reg <= cfg_wr_data;
                    glos_pkg::REG_CENTER_Y:     center_y_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
        a_reg      <= a_next;
        d_reg      <= d_next;
        mdb_reg    <= mdb_next;
        rrow_reg   <= rrow_next;
        p_prev_reg <= p_prev_next;
        p_cur_reg  <= p_cur_next;
        r_cur_reg  <= r_cur_next;
        q_row_reg  <= q_row_next;
        q_col_reg  <= q_col_next;
        q_ring_reg <= q_ring_next;
        q_ok_reg   <= q_ok_next;
        vis_reg    <= vis_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(glos_pkg::M_TDATA_W - DW){1'b0}}, vis_reg};

endmodule

`default_nettype wire

/* rtl/core/glos_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module glos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire [WIDTH-1:0]          wr_data,
    input  wire [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/core/glos_checker.sv */
// Port-level checks for the line-of-sight block, bound to the top level.
// Depends on glos_pkg.
`default_nettype none

module glos_checker (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                s_tvalid,
    input wire                                s_tready,
    input wire                                s_tuser,
    input wire                                m_tvalid,
    input wire                                m_tready,
    input wire [glos_pkg::M_TDATA_W-1:0]      m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // visibility stays below the clamped range, fill bits stay zero
    a_vis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[glos_pkg::M_TDATA_W-1:glos_pkg::DIST_W] == '0) &&
                     (m_tdata[glos_pkg::DIST_W-1:0] < 5'd16))
        else $error("visibility out of range");

    // query into an empty output register shows its result after the address and result states
    a_query_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == glos_pkg::CMD_QUERY) && !m_tvalid |-> ##3 m_tvalid)
        else $error("query result missing");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind grid_line_of_sight_wavefront glos_checker u_glos_checker (.*);

`default_nettype wire

/* tb/sv/grid_line_of_sight_wavefront_test.sv */
// Testbench for grid_line_of_sight_wavefront: random loads and queries against a
// built-in predictor of the sight table. Depends on glos_pkg and the block's RTL.
`timescale 1ns / 100ps

module grid_line_of_sight_wavefront_test;

    localparam int WIN           = glos_pkg::WIN;
    localparam int WINDOW_RADIUS = glos_pkg::WINDOW_RADIUS;
    localparam int MAP_SIZE      = glos_pkg::MAP_SIZE;
    localparam int CFG_IDX_W     = glos_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = glos_pkg::CFG_DATA_W;
    localparam int S_TDATA_W     = glos_pkg::S_TDATA_W;
    localparam int M_TDATA_W     = glos_pkg::M_TDATA_W;

    localparam int IDLE_LIMIT  = 20000;
    localparam int BUILD_WAIT  = 400;   // covers seeding plus every ring sweep
    localparam int NUM_PHASES  = 7;
    localparam int RANDOM_ITEMS = 25;

    class vis_scoreboard;
        logic [4:0]     max_dist;
        logic           door_en;
        logic [9:0]     door_px, door_py, view_x, view_y;
        logic [WIN-1:0] block_rows [WIN];
        logic [WIN-1:0] door_rows [WIN];
        logic [4:0]     sight [WIN][WIN];
        logic [4:0]     expected_vis [$];
        int             errors;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            unique case (idx)
                glos_pkg::REG_MAX_DISTANCE: max_dist = val[4:0];
                glos_pkg::REG_DOOR_ENABLE:  door_en  = val[0];
                glos_pkg::REG_DOOR_X:       door_px  = val[9:0];
                glos_pkg::REG_DOOR_Y:       door_py  = val[9:0];
                glos_pkg::REG_CENTER_X:     view_x   = val[9:0];
                glos_pkg::REG_CENTER_Y:     view_y   = val[9:0];
                default: ;
            endcase
        endfunction

        function void clear_all();
            max_dist = 5'd16;
            door_en = 1'b0;
            door_px = '0;
            door_py = '0;
            view_x = '0;
            view_y = '0;
            errors = 0;
            for (int r = 0; r < WIN; r++) begin
                block_rows[r] = '0;
                door_rows[r] = '0;
                for (int c = 0; c < WIN; c++) sight[r][c] = '0;
            end
        endfunction

        function int clamp_md();
            return (int'(max_dist) > WINDOW_RADIUS) ? WINDOW_RADIUS : int'(max_dist);
        endfunction

        function bit is_clear(int ox, int oy);
            int ax, ay, col, row;
            ax = int'(view_x) + ox;
            ay = int'(view_y) + oy;
            col = ox + WINDOW_RADIUS;
            row = oy + WINDOW_RADIUS;
            if (ax < 1 || ax >= MAP_SIZE || ay < 1 || ay >= MAP_SIZE) return 0;
            if (col < 0 || col >= WIN || row < 0 || row >= WIN) return 0;
            if (door_en && door_rows[row][col] && (ax != int'(door_px) || ay != int'(door_py)))
                return 1;
            return !block_rows[row][col];
        endfunction

        function logic [4:0] cell_at(int ox, int oy);
            int c, r;
            c = ox + WINDOW_RADIUS;
            r = oy + WINDOW_RADIUS;
            if (c < 0 || c >= WIN || r < 0 || r >= WIN) return '0;
            return sight[r][c];
        endfunction

        function void mark(int ox, int oy, int v);
            int c, r;
            c = ox + WINDOW_RADIUS;
            r = oy + WINDOW_RADIUS;
            if (c < 0 || c >= WIN || r < 0 || r >= WIN) return;
            if (sight[r][c] == 0) sight[r][c] = v[4:0];
        endfunction

        // inward step (ix,iy), sideways step (px,py)
        function bit reached(int ox, int oy, int ix, int iy, int px, int py, int d);
            int nx, ny;
            for (int k = -1; k <= 1; k++) begin
                nx = ox + ix + k * px;
                ny = oy + iy + k * py;
                if (int'(cell_at(nx, ny)) == d && is_clear(nx, ny)) return 1;
            end
            return 0;
        endfunction

        function void build_sight();
            int  md;
            bit  grew;
            md = clamp_md();
            for (int r = 0; r < WIN; r++)
                for (int c = 0; c < WIN; c++) sight[r][c] = '0;
            mark(0, 0, 1);
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++) mark(dx, dy, 2);
            for (int d = 2; d < md; d++) begin
                grew = 0;
                for (int i = -d; i <= d; i++) begin
                    if (reached(i, -d, 0, 1, 1, 0, d)) begin mark(i, -d, d + 1); grew = 1; end
                    if (reached(i, d, 0, -1, 1, 0, d)) begin mark(i, d, d + 1); grew = 1; end
                end
                for (int i = -d; i <= d; i++) begin
                    if (reached(-d, i, 1, 0, 0, 1, d)) begin mark(-d, i, d + 1); grew = 1; end
                    if (reached(d, i, -1, 0, 0, 1, d)) begin mark(d, i, d + 1); grew = 1; end
                end
                if (!grew) break;
            end
        endfunction

        function void note_input(logic cmd, logic [5:0] row, logic [WIN-1:0] blk,
                                 logic [WIN-1:0] dr, logic [9:0] tx, logic [9:0] ty);
            int ox, oy, ax, ay, md;
            logic [4:0] v;
            if (cmd == glos_pkg::CMD_LOAD) begin
                if (int'(row) < WIN) begin
                    block_rows[row] = blk;
                    door_rows[row] = dr;
                    if (int'(row) == WIN - 1) build_sight();
                end
            end else begin
                ox = int'(tx) - int'(view_x);
                oy = int'(ty) - int'(view_y);
                ax = ox < 0 ? -ox : ox;
                ay = oy < 0 ? -oy : oy;
                md = clamp_md();
                v = '0;
                if (ax < int'(max_dist) && ay < int'(max_dist) && ax < md && ay < md) begin
                    v = cell_at(ox, oy);
                    if (int'(v) >= md) v = '0;
                end
                expected_vis.push_back(v);
            end
        endfunction

        function void check(logic [M_TDATA_W-1:0] data);
            logic [4:0] exp_v;
            if (expected_vis.size() == 0) begin
                $error("visibility: unexpected beat, actual %0d", data[4:0]);
                errors++;
                return;
            end
            exp_v = expected_vis.pop_front();
            if (data[4:0] !== exp_v) begin
                $error("visibility: expected %0d, actual %0d", exp_v, data[4:0]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [M_TDATA_W-1:0]  m_tdata;

    vis_scoreboard vis_sb = new();
    int            burst_left = 0;
    int            stall_mode = 0;
    int            idle_cycles = 0;
    int            block_mode = 0;

    always #5 aclk = ~aclk;

    grid_line_of_sight_wavefront dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // receiver: stall style changes at random times, mode 0 never stalls
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) vis_sb.check(m_tdata);
        if ($urandom_range(0, 63) == 0) stall_mode <= int'($urandom_range(0, 3));
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 9) == 0);
            default: m_tready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("grid_line_of_sight_wavefront test failed");
            $finish;
        end
    end

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        vis_sb.set_reg(idx, val);
    endtask

    task automatic send_beat(logic cmd, logic [5:0] row, logic [WIN-1:0] blk,
                             logic [WIN-1:0] dr, logic [9:0] tx, logic [9:0] ty);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = int'($urandom_range(1, 20));
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'b0, ty, tx, dr, blk, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        vis_sb.note_input(cmd, row, blk, dr, tx, ty);
    endtask

    function automatic logic [WIN-1:0] rand_row();
        logic [WIN-1:0] a, b;
        a = WIN'({$urandom, $urandom});
        b = WIN'({$urandom, $urandom});
        case (block_mode)
            0: return '0;
            1: return a & b & WIN'({$urandom, $urandom});
            2: return a & b;
            3: return '1;
            default: return a;
        endcase
    endfunction

    function automatic logic [9:0] near(logic [9:0] c, int span);
        return 10'(int'(c) + $urandom_range(0, 2 * span) - span);
    endfunction

    task automatic load_rows();
        for (int r = 0; r < WIN; r++)
            send_beat(glos_pkg::CMD_LOAD, 6'(r), rand_row(), WIN'({$urandom, $urandom}),
                      10'($urandom), 10'($urandom));
    endtask

    task automatic send_query(logic [9:0] tx, logic [9:0] ty);
        send_beat(glos_pkg::CMD_QUERY, 6'($urandom), WIN'({$urandom, $urandom}),
                  WIN'({$urandom, $urandom}), tx, ty);
    endtask

    task automatic wait_idle();
        if (s_tvalid) s_tvalid <= 1'b0;
        while (vis_sb.expected_vis.size() != 0) @(posedge aclk);
        repeat (BUILD_WAIT) @(posedge aclk);
    endtask

    initial begin
        logic [4:0] md_val;
        logic [9:0] cx, cy;
        vis_sb.clear_all();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // nothing built yet: every query reads zero; loads past the window are dropped
        send_query(10'd0, 10'd0);
        send_query(10'd1023, 10'd1023);
        send_beat(glos_pkg::CMD_LOAD, 6'd33, '1, '1, 10'd0, 10'd0);
        send_beat(glos_pkg::CMD_LOAD, 6'd63, '1, '1, 10'd1023, 10'd1023);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin md_val = 5'd16; cx = 10'd512; cy = 10'd512; block_mode = 0; end
                1: begin md_val = 5'd1;  cx = 10'd0;   cy = 10'd1023; block_mode = 2; end
                2: begin md_val = 5'd16; cx = 10'd1023; cy = 10'd5;  block_mode = 1; end
                3: begin md_val = 5'd2;  cx = 10'd1;   cy = 10'd1;   block_mode = 3; end
                4: begin md_val = 5'd3;  cx = 10'd20;  cy = 10'd1010; block_mode = 1; end
                default: begin
                    md_val = 5'($urandom_range(1, 16));
                    cx = 10'($urandom); cy = 10'($urandom);
                    block_mode = int'($urandom_range(1, 4));
                end
            endcase
            write_reg(glos_pkg::REG_MAX_DISTANCE, 10'(md_val));
            write_reg(glos_pkg::REG_DOOR_ENABLE, 10'(ph % 3 != 1));
            write_reg(glos_pkg::REG_CENTER_X, cx);
            write_reg(glos_pkg::REG_CENTER_Y, cy);
            write_reg(glos_pkg::REG_DOOR_X, ph == 0 ? 10'd1023 : near(cx, 3));
            write_reg(glos_pkg::REG_DOOR_Y, ph == 0 ? 10'd0 : near(cy, 3));
            cfg_wr_en <= 1'b0;
            load_rows();

            // edges of the sight range around the viewer
            send_query(cx, cy);
            send_query(10'(cx + md_val - 1), 10'(cy - md_val + 1));
            send_query(10'(cx + md_val), cy);
            send_query(cx, 10'(cy - md_val));

            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                if ($urandom_range(0, 6) == 0)
                    send_beat(glos_pkg::CMD_LOAD, 6'($urandom_range(0, 40)), rand_row(),
                              WIN'({$urandom, $urandom}), 10'($urandom), 10'($urandom));
                else if ($urandom_range(0, 4) == 0)
                    send_query(10'($urandom), 10'($urandom));
                else
                    send_query(near(cx, 17), near(cy, 17));
            end
        end

        s_tvalid <= 1'b0;
        while (vis_sb.expected_vis.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (vis_sb.errors == 0)
            $display("grid_line_of_sight_wavefront test passed");
        else
            $display("grid_line_of_sight_wavefront test failed");
        $finish;
    end

endmodule
